/* sv/gcm_pkg.sv */
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared types and constants for the graph contraction matrix.
// ----------------------------------------------------------------------------
package gcm_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int KIND_W   = 2;
  localparam int VERT_W   = 6;
  localparam int WIN_W    = 16;
  localparam int CFG_W    = 7;
  localparam int VCOUNT_W = 7;
  localparam int ECOUNT_W = 12;
  localparam int TOTAL_W  = 27;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_WRITE    = 2'd0;
  localparam kind_t KIND_CONTRACT = 2'd1;
  localparam kind_t KIND_CLR_DIAG = 2'd2;
  localparam kind_t KIND_REPORT   = 2'd3;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

endpackage

/* sv/gcm_ram.sv */
// ----------------------------------------------------------------------------
// gcm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/graph_contraction_matrix.sv */
// ----------------------------------------------------------------------------
// graph_contraction_matrix: a write, a flagged item, a self contraction and a
// clear diagonal or report with n = 0 go straight to the result stage. A
// contraction reads the source, clears it and reads the destination, then
// writes the destination, per row and column entry; clear diagonal writes each
// diagonal entry; a report does one RAM read per entry. n = vertices used. Input
// stalls until the result register is loaded: no new transaction while one runs.
// Reset: zeroing sweep of all MAX_VERTICES^2 matrix RAM entries, input stalled.
module graph_contraction_matrix #(
  parameter int MAX_VERTICES = gcm_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = gcm_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gcm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  gcm_pkg::kind_t                in_kind,
  input  logic [gcm_pkg::VERT_W-1:0]    in_vertex_a,
  input  logic [gcm_pkg::VERT_W-1:0]    in_vertex_b,
  input  logic [gcm_pkg::WIN_W-1:0]     in_weight,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [gcm_pkg::VCOUNT_W-1:0]  out_vertex_count,
  output logic [gcm_pkg::ECOUNT_W-1:0]  out_edge_count,
  output logic [gcm_pkg::TOTAL_W-1:0]   out_total_weight
);

  import gcm_pkg::*;

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int NW    = (VW + 1 > CFG_W) ? VW + 1 : CFG_W;
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int WB    = WEIGHT_BITS;
  localparam int CW    = VW + 1;
  localparam int EW    = 2 * VW + 1;
  localparam int TW    = 2 * VW + WB;

  localparam logic [32:0] WMAX33 = (33'd1 << WB) - 33'd1;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CT   = 3'd2;
  localparam logic [2:0] S_DIAG = 3'd3;
  localparam logic [2:0] S_REP  = 3'd4;
  localparam logic [2:0] S_DRN  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [1:0] PH_RD_SRC = 2'd0;
  localparam logic [1:0] PH_CLR    = 2'd1;
  localparam logic [1:0] PH_WR_DST = 2'd2;

  function automatic logic [AW-1:0] mat_addr(input logic [VW-1:0] r,
                                             input logic [VW-1:0] c);
    mat_addr = AW'(r) * AW'(MAX_VERTICES) + AW'(c);
  endfunction

  // control
  logic [2:0]       state_r, state_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic             half_r, half_nxt;
  logic [NW-1:0]    i_r, i_nxt;
  logic [NW-1:0]    j_r, j_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [CFG_W-1:0] cfg_r;
  logic             pv_r, pv_nxt;
  logic             out_valid_r;

  // payload
  logic [VW-1:0]    a_r, a_nxt;
  logic [VW-1:0]    b_r, b_nxt;
  logic [WB-1:0]    e_r, e_nxt;
  logic             status_r, status_nxt;
  logic             plast_r, plast_nxt;
  logic             row_any_r, row_any_nxt;
  logic [CW-1:0]    vcnt_r, vcnt_nxt;
  logic [EW-1:0]    ecnt_r, ecnt_nxt;
  logic [TW-1:0]    tot_r, tot_nxt;
  logic                out_status_r;
  logic [VCOUNT_W-1:0] out_vc_r;
  logic [ECOUNT_W-1:0] out_ec_r;
  logic [TOTAL_W-1:0]  out_tw_r;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WB-1:0] ram_wdata, ram_rdata;

  logic [NW-1:0] n_w;
  logic          accept, a_ok, b_ok, i_last, j_last, out_free;
  logic [VW-1:0] in_a_v, in_b_v;
  logic [32:0]   w33, ws33;
  logic [WB:0]   sum_w;
  logic [WB-1:0] sat_w;
  logic [AW-1:0] src_addr, dst_addr;
  logic          nz;
  logic [63:0]   vc_ext, ec_ext, tw_ext;

  gcm_ram #(
    .WIDTH(WB),
    .DEPTH(DEPTH)
  ) u_mat (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign n_w = (NW'(cfg_r) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(cfg_r);

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign a_ok   = NW'(in_vertex_a) < n_w;
  assign b_ok   = NW'(in_vertex_b) < n_w;
  assign in_a_v = VW'(in_vertex_a);
  assign in_b_v = VW'(in_vertex_b);
  assign i_last = (i_r + NW'(1)) == n_w;
  assign j_last = (j_r + NW'(1)) == n_w;

  assign w33  = 33'(in_weight);
  assign ws33 = (w33 > WMAX33) ? WMAX33 : w33;

  assign sum_w = {1'b0, e_r} + {1'b0, ram_rdata};
  assign sat_w = sum_w[WB] ? {WB{1'b1}} : sum_w[WB-1:0];

  // row half moves (b,i) onto (a,i); column half moves (i,b) onto (i,a)
  assign src_addr = half_r ? mat_addr(i_r[VW-1:0], b_r) : mat_addr(b_r, i_r[VW-1:0]);
  assign dst_addr = half_r ? mat_addr(i_r[VW-1:0], a_r) : mat_addr(a_r, i_r[VW-1:0]);

  assign nz = (ram_rdata != '0);

  always_comb begin
    state_nxt   = state_r;
    ph_nxt      = ph_r;
    half_nxt    = half_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    clr_nxt     = clr_r;
    pv_nxt      = 1'b0;
    plast_nxt   = 1'b0;
    a_nxt       = a_r;
    b_nxt       = b_r;
    e_nxt       = e_r;
    status_nxt  = status_r;
    row_any_nxt = row_any_r;
    vcnt_nxt    = vcnt_r;
    ecnt_nxt    = ecnt_r;
    tot_nxt     = tot_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    // report data returns in the cycle after its read
    if (pv_r) begin
      ecnt_nxt = ecnt_r + EW'(nz);
      tot_nxt  = tot_r + TW'(ram_rdata);
      if (plast_r) begin
        vcnt_nxt    = vcnt_r + CW'(row_any_r | nz);
        row_any_nxt = 1'b0;
      end else begin
        row_any_nxt = row_any_r | nz;
      end
    end

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          a_nxt       = in_a_v;
          b_nxt       = in_b_v;
          i_nxt       = '0;
          j_nxt       = '0;
          ph_nxt      = PH_RD_SRC;
          half_nxt    = 1'b0;
          status_nxt  = STATUS_DONE;
          row_any_nxt = 1'b0;
          vcnt_nxt    = '0;
          ecnt_nxt    = '0;
          tot_nxt     = '0;
          state_nxt   = S_FIN;
          case (in_kind)
            KIND_WRITE: begin
              if (a_ok && b_ok) begin
                ram_we    = 1'b1;
                ram_waddr = mat_addr(in_a_v, in_b_v);
                ram_wdata = ws33[WB-1:0];
              end else begin
                status_nxt = STATUS_RANGE;
              end
            end
            KIND_CONTRACT: begin
              if (!(a_ok && b_ok)) begin
                status_nxt = STATUS_RANGE;
              end else if (in_vertex_a != in_vertex_b) begin
                state_nxt = S_CT;
              end
            end
            KIND_CLR_DIAG: begin
              if (n_w != '0) begin
                state_nxt = S_DIAG;
              end
            end
            KIND_REPORT: begin
              if (n_w != '0) begin
                state_nxt = S_REP;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_CT: begin
        case (ph_r)
          PH_RD_SRC: begin
            ram_re    = 1'b1;
            ram_raddr = src_addr;
            ph_nxt    = PH_CLR;
          end
          PH_CLR: begin
            e_nxt     = ram_rdata;
            ram_we    = 1'b1;
            ram_waddr = src_addr;
            ram_re    = 1'b1;
            ram_raddr = dst_addr;
            ph_nxt    = PH_WR_DST;
          end
          PH_WR_DST: begin
            ram_we    = 1'b1;
            ram_waddr = dst_addr;
            ram_wdata = sat_w;
            ph_nxt    = PH_RD_SRC;
            half_nxt  = !half_r;
            if (half_r) begin
              i_nxt = i_r + NW'(1);
              if (i_last) begin
                state_nxt = S_FIN;
              end
            end
          end
          default: begin
            ph_nxt = PH_RD_SRC;
          end
        endcase
      end
      S_DIAG: begin
        ram_we    = 1'b1;
        ram_waddr = mat_addr(i_r[VW-1:0], i_r[VW-1:0]);
        i_nxt     = i_r + NW'(1);
        if (i_last) begin
          state_nxt = S_FIN;
        end
      end
      S_REP: begin
        ram_re    = 1'b1;
        ram_raddr = mat_addr(i_r[VW-1:0], j_r[VW-1:0]);
        pv_nxt    = 1'b1;
        plast_nxt = j_last;
        if (j_last) begin
          j_nxt = '0;
          i_nxt = i_r + NW'(1);
          if (i_last) begin
            state_nxt = S_DRN;
          end
        end else begin
          j_nxt = j_r + NW'(1);
        end
      end
      S_DRN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // halve the edge count and total weight, and clamp all three to the result field widths
  assign vc_ext = 64'(vcnt_r);
  assign ec_ext = 64'(ecnt_r >> 1);
  assign tw_ext = 64'(tot_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ph_r        <= PH_RD_SRC;
      half_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      clr_r       <= '0;
      cfg_r       <= CFG_RESET;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      half_r  <= half_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      clr_r   <= clr_nxt;
      pv_r    <= pv_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    e_r       <= e_nxt;
    status_r  <= status_nxt;
    plast_r   <= plast_nxt;
    row_any_r <= row_any_nxt;
    vcnt_r    <= vcnt_nxt;
    ecnt_r    <= ecnt_nxt;
    tot_r     <= tot_nxt;
    if (state_r == S_FIN && out_free) begin
      out_status_r <= status_r;
      out_vc_r     <= (vc_ext > 64'({VCOUNT_W{1'b1}})) ? {VCOUNT_W{1'b1}}
                                                        : vc_ext[VCOUNT_W-1:0];
      out_ec_r     <= (ec_ext > 64'({ECOUNT_W{1'b1}})) ? {ECOUNT_W{1'b1}}
                                                        : ec_ext[ECOUNT_W-1:0];
      out_tw_r     <= (tw_ext > 64'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}}
                                                       : tw_ext[TOTAL_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_vertex_count = out_vc_r;
  assign out_edge_count   = out_ec_r;
  assign out_total_weight = out_tw_r;

endmodule

/* dv/graph_contraction_matrix_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_contraction_matrix_test
// Self-checking bench: a clocked driver feeds entry writes, contractions,
// diagonal clears and reports from a backlog queue. A mirror of the weight
// matrix predicts each result on acceptance, and a clocked monitor checks
// every result field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module graph_contraction_matrix_test;
  import gcm_pkg::*;

  localparam int NV = MAX_VERTICES_DEF;
  localparam int unsigned WMAX = (1 << WEIGHT_BITS_DEF) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    kind_t             kind;
    logic [VERT_W-1:0] a;
    logic [VERT_W-1:0] b;
    logic [WIN_W-1:0]  w;
  } item_t;

  typedef struct packed {
    item_t               src;
    logic                status;
    logic [VCOUNT_W-1:0] vcount;
    logic [ECOUNT_W-1:0] ecount;
    logic [TOTAL_W-1:0]  total;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  kind_t               in_kind = KIND_WRITE;
  logic [VERT_W-1:0]   in_vertex_a = '0;
  logic [VERT_W-1:0]   in_vertex_b = '0;
  logic [WIN_W-1:0]    in_weight = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_status;
  logic [VCOUNT_W-1:0] out_vertex_count;
  logic [ECOUNT_W-1:0] out_edge_count;
  logic [TOTAL_W-1:0]  out_total_weight;

  graph_contraction_matrix DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_vertex_a      (in_vertex_a),
    .in_vertex_b      (in_vertex_b),
    .in_weight        (in_weight),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_vertex_count (out_vertex_count),
    .out_edge_count   (out_edge_count),
    .out_total_weight (out_total_weight)
  );

  always #6 clk = ~clk;

  // Mirror of the block state
  bit [WIN_W-1:0]   weight_mirror [NV][NV];
  logic [CFG_W-1:0] cfg_mirror = CFG_RESET;

  item_t    item_backlog[$];
  outcome_t awaited_outcomes[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;

  int unsigned mismatches = 0;
  int unsigned n_results = 0;
  int unsigned n_reports = 0;
  int unsigned n_flagged = 0;
  int unsigned n_settings = 0;

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTED)
      $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned clamp_vertices(input logic [CFG_W-1:0] v);
    return (v > NV) ? NV : v;
  endfunction

  function automatic bit [WIN_W-1:0] sat_sum(input bit [WIN_W-1:0] x, input bit [WIN_W-1:0] y);
    int unsigned s;
    s = int'(x) + int'(y);
    return (s > WMAX) ? WMAX[WIN_W-1:0] : s[WIN_W-1:0];
  endfunction

  // Updates the mirror with one accepted transaction and returns its result
  function automatic outcome_t apply_to_matrix(input item_t it);
    outcome_t        o;
    int unsigned     n, i, j, vc, ec;
    longint unsigned tot;
    bit [WIN_W-1:0]  e;
    bit              any;
    o = '0;
    o.src = it;
    o.status = STATUS_DONE;
    n = clamp_vertices(cfg_mirror);
    vc = 0;
    ec = 0;
    tot = 0;
    case (it.kind)
      KIND_WRITE: begin
        if (it.a < n && it.b < n)
          weight_mirror[it.a][it.b] = (it.w > WMAX) ? WMAX[WIN_W-1:0] : it.w;
        else
          o.status = STATUS_RANGE;
      end
      KIND_CONTRACT: begin
        if (it.a < n && it.b < n) begin
          // row entry first, then column entry, at each step
          for (i = 0; i < n; i++) begin
            e = weight_mirror[it.b][i];
            weight_mirror[it.b][i] = '0;
            weight_mirror[it.a][i] = sat_sum(e, weight_mirror[it.a][i]);
            e = weight_mirror[i][it.b];
            weight_mirror[i][it.b] = '0;
            weight_mirror[i][it.a] = sat_sum(e, weight_mirror[i][it.a]);
          end
        end else begin
          o.status = STATUS_RANGE;
        end
      end
      KIND_CLR_DIAG: begin
        for (i = 0; i < n; i++)
          weight_mirror[i][i] = '0;
      end
      default: begin
        for (i = 0; i < n; i++) begin
          any = 1'b0;
          for (j = 0; j < n; j++) begin
            if (weight_mirror[i][j] != 0) begin
              any = 1'b1;
              ec++;
            end
            tot += weight_mirror[i][j];
          end
          if (any)
            vc++;
        end
        ec = ec >> 1;
        tot = tot >> 1;
        o.vcount = (vc > 127) ? 7'h7F : vc[VCOUNT_W-1:0];
        o.ecount = (ec > 4095) ? 12'hFFF : ec[ECOUNT_W-1:0];
        o.total = (tot > 64'h7FFFFFF) ? 27'h7FFFFFF : tot[TOTAL_W-1:0];
      end
    endcase
    return o;
  endfunction

  function automatic void queue_item(input kind_t k, input int unsigned a, input int unsigned b,
                                     input int unsigned w);
    item_t it;
    it.kind = k;
    it.a = a[VERT_W-1:0];
    it.b = b[VERT_W-1:0];
    it.w = w[WIN_W-1:0];
    item_backlog = {item_backlog, it};
  endfunction

  function automatic int unsigned pick_vertex(input int unsigned n);
    if (n == 0 || $urandom_range(99) < 12)
      return $urandom_range(NV - 1);
    return $urandom_range(n - 1);
  endfunction

  function automatic item_t random_item(input int unsigned n, input int unsigned report_pct);
    item_t       it;
    int unsigned r;
    r = $urandom_range(99);
    if (r < report_pct) begin
      it.kind = KIND_REPORT;
    end else begin
      r = $urandom_range(99);
      it.kind = (r < 55) ? KIND_WRITE : (r < 90) ? KIND_CONTRACT : KIND_CLR_DIAG;
    end
    it.a = VERT_W'(pick_vertex(n));
    it.b = VERT_W'(pick_vertex(n));
    r = $urandom_range(99);
    // heavy weights push contractions into saturation
    if (r < 25)
      it.w = WIN_W'($urandom_range(16'hFFFF, 16'hF000));
    else if (r < 35)
      it.w = '0;
    else if (r < 75)
      it.w = WIN_W'($urandom_range(255, 1));
    else
      it.w = WIN_W'($urandom_range(16'hFFFF));
    return it;
  endfunction

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        awaited_outcomes = {awaited_outcomes,
                            apply_to_matrix({in_kind, in_vertex_a, in_vertex_b, in_weight})};
      if (!in_valid || !in_stall) begin
        if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_kind <= item_backlog[0].kind;
          in_vertex_a <= item_backlog[0].a;
          in_vertex_b <= item_backlog[0].b;
          in_weight <= item_backlog[0].w;
          void'(item_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk) begin
    if (hold_start)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 1'b0;
    else
      out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // Monitor
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (awaited_outcomes.size() == 0) begin
        flag_mismatch("result transaction with nothing outstanding");
      end else begin
        e = awaited_outcomes.pop_front();
        if (e.src.kind == KIND_REPORT)
          n_reports++;
        if (e.status == STATUS_RANGE)
          n_flagged++;
        if (out_status !== e.status)
          flag_mismatch($sformatf("kind %0d a %0d b %0d: status %b, want %b",
                        e.src.kind, e.src.a, e.src.b, out_status, e.status));
        if (out_vertex_count !== e.vcount)
          flag_mismatch($sformatf("kind %0d a %0d b %0d: vertex_count %0d, want %0d",
                        e.src.kind, e.src.a, e.src.b, out_vertex_count, e.vcount));
        if (out_edge_count !== e.ecount)
          flag_mismatch($sformatf("kind %0d a %0d b %0d: edge_count %0d, want %0d",
                        e.src.kind, e.src.a, e.src.b, out_edge_count, e.ecount));
        if (out_total_weight !== e.total)
          flag_mismatch($sformatf("kind %0d a %0d b %0d: total_weight %0d, want %0d",
                        e.src.kind, e.src.a, e.src.b, out_total_weight, e.total));
      end
    end
  end

  task automatic write_config(input int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_mirror = v[CFG_W-1:0];
    n_settings++;
  endtask

  // Sender stays quiet until every outstanding result is back
  task automatic settle();
    @(negedge clk);
    while (item_backlog.size() != 0 || in_valid || awaited_outcomes.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int unsigned settings [16] = '{1, 2, 4, 8, 3, 16, 5, 0, 12, 64, 6, 127, 10, 7, 2, 90};
    int unsigned p, k, n, cnt, rp;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // corners at the reset size, saturating and self contraction
    queue_item(KIND_WRITE, 0, 0, 16'hFFFF);
    queue_item(KIND_WRITE, 63, 63, 16'hFFFF);
    queue_item(KIND_WRITE, 0, 63, 16'hFFFF);
    queue_item(KIND_WRITE, 63, 0, 1);
    queue_item(KIND_WRITE, 5, 5, 16'h1234);
    queue_item(KIND_REPORT, 0, 0, 0);
    queue_item(KIND_CONTRACT, 0, 63, 0);
    queue_item(KIND_CONTRACT, 5, 5, 16'hFFFF);
    queue_item(KIND_REPORT, 63, 63, 16'hFFFF);
    queue_item(KIND_CLR_DIAG, 0, 0, 0);
    queue_item(KIND_REPORT, 0, 0, 0);
    settle();

    // out-of-range vertices on both fields
    write_config(3);
    queue_item(KIND_WRITE, 3, 0, 7);
    queue_item(KIND_WRITE, 0, 3, 7);
    queue_item(KIND_CONTRACT, 1, 63, 0);
    queue_item(KIND_CONTRACT, 63, 1, 0);
    queue_item(KIND_WRITE, 1, 2, 16'hAAAA);
    queue_item(KIND_WRITE, 2, 1, 16'h5555);
    queue_item(KIND_CONTRACT, 0, 1, 0);
    queue_item(KIND_REPORT, 0, 0, 0);
    settle();

    // no vertex in range
    write_config(0);
    queue_item(KIND_WRITE, 0, 0, 5);
    queue_item(KIND_CONTRACT, 0, 0, 0);
    queue_item(KIND_CLR_DIAG, 0, 0, 0);
    queue_item(KIND_REPORT, 0, 0, 0);
    settle();

    // register above the vertex count
    write_config(127);
    queue_item(KIND_REPORT, 0, 0, 0);
    settle();

    for (p = 0; p < 16; p++) begin
      write_config(settings[p]);
      @(negedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      n = clamp_vertices(CFG_W'(settings[p]));
      // large sizes make reports slow: few items there
      cnt = (n == NV) ? 30 : 110;
      rp = (n == NV) ? 5 : 15;
      for (k = 0; k < cnt; k++)
        item_backlog = {item_backlog, random_item(n, rp)};
      if (p == 3) begin
        send_idle_pct = 0;
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      settle();
    end

    repeat (NV * NV + 16) @(posedge clk);
    if (awaited_outcomes.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", awaited_outcomes.size()));

    $display("Checked %0d result transactions (%0d reports, %0d flagged out of range)",
             n_results, n_reports, n_flagged);
    $display("over %0d vertex-count settings, including zero, one and above the matrix size",
             n_settings);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #72_000_000;
    $display("Timeout waiting for results");
    $display("Mismatches found");
    $finish;
  end

endmodule
